### rtl/assert_macros.svh
// Assertion macros shared by the tape pulse timer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tpt: invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpt: implication violated");

`endif

### rtl/tpt_pkg.sv
// Shared types and constants of the tape pulse timer.
// Depends on nothing; imported by every module of the block.
package tpt_pkg;

  // Image bytes skipped at the start of the tape.
  localparam int HEADER_BYTES = 20;
  // Width of the pulse down-counter and of the late-cycle counter.
  localparam int COUNT_BITS = 24;
  // Width of the byte position and of the tape length register.
  localparam int POS_W = 24;
  // Entries in the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_BYTE    = 3'd1,
    OP_MOTOR   = 3'd2,
    OP_PLAY    = 3'd3,
    OP_RESTART = 3'd4
  } op_e;

  // Decoded command kinds handed from front to back.
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_BYTE,
    CMD_MOTOR,
    CMD_PLAY,
    CMD_RESTART,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic pulse_interrupt;
    logic need_byte;
    logic end_of_tape;
    logic motor_off_bit;
    logic play_released_bit;
  } out_item_t;

  // Classified command as it travels through the queue.
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] value;
    logic       byte_zero;  // Image byte is zero: a long-form length follows.
    logic       motor_run;  // Motor control bit decoded: 1 means run.
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

### rtl/tape_pulse_timer.sv
// Tape pulse timer: plays a TAP version 1 image as timed pulses.
// Uses the tpt front, queue and back modules and tpt_pkg.
//
// Usage: items enter on the in channel (valid/ready). Operation 0 is one
// machine-cycle tick, 1 delivers the next image byte, 2 writes the motor
// control bit, 3 toggles the play button and 4 restarts the attached tape.
// Every item yields exactly one result on the out channel (valid/ready),
// in order, carrying the pulse interrupt and the status bits after the
// item took effect. The tape length is written through cfg_we_i and
// cfg_wdata_i while the block is idle.
// An item is stored in the command queue, and its result is registered when
// the back end takes it. Throughput: one item per cycle while out_ready_i
// is high; the back end retires one command a cycle and updates the counters.
// A two-entry command queue sits between decode and execution, and the
// result register lets a new item enter while a result waits.
// Reset clears the pulse, position, late cycles, long-form state, motor
// (stopped), play (released) and the tape length. When the receiver
// stalls, the result holds, the queue fills, and in_ready_o drops after
// at most two more transfers.
module tape_pulse_timer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tpt_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tpt_pkg::out_item_t         out_data_o,
  input  logic                       cfg_we_i,
  input  logic [tpt_pkg::POS_W-1:0]  cfg_wdata_i
);
  import tpt_pkg::*;

  logic [POS_W-1:0] tape_length_q;
  cmd_t             front_cmd;
  q_head_t          head;
  logic             q_full;
  logic             pop;

  // Tape length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_length_q <= '0;
    end else if (cfg_we_i) begin
      tape_length_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !q_full;

  tpt_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd)
  );

  tpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head)
  );

  tpt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tape_length_i (tape_length_q),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

### rtl/tpt_front.sv
// Front end of the tape pulse timer: decodes input items into commands.
// Depends on tpt_pkg.
module tpt_front (
  input  tpt_pkg::in_item_t in_data_i,
  output tpt_pkg::cmd_t     cmd_o
);
  import tpt_pkg::*;

  // Classify the operation code; unused codes become no-ops.
  always_comb begin
    cmd_o.value     = in_data_i.value;
    cmd_o.byte_zero = (in_data_i.value == 8'd0);
    cmd_o.motor_run = ~in_data_i.value[0];
    case (in_data_i.operation)
      OP_TICK:    cmd_o.kind = CMD_TICK;
      OP_BYTE:    cmd_o.kind = CMD_BYTE;
      OP_MOTOR:   cmd_o.kind = CMD_MOTOR;
      OP_PLAY:    cmd_o.kind = CMD_PLAY;
      OP_RESTART: cmd_o.kind = CMD_RESTART;
      default:    cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

### rtl/tpt_queue.sv
// Short command queue between the front and back ends of the tape pulse timer.
// Depends on tpt_pkg.
module tpt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpt_pkg::cmd_t     push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output tpt_pkg::q_head_t  head_o
);
  import tpt_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  // Pointer and fill-count update with wraparound at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/tpt_back.sv
// Back end of the tape pulse timer: pulse counter, byte decoder and result register.
// Depends on tpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [tpt_pkg::POS_W-1:0] tape_length_i,
  input  tpt_pkg::q_head_t      head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tpt_pkg::out_item_t    out_data_o
);
  import tpt_pkg::*;

  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic                  loaded_q, loaded_d;
  logic [COUNT_BITS-1:0] late_q, late_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [1:0]            phase_q, phase_d;
  logic [23:0]           lval_q, lval_d;
  logic                  motor_q, motor_d;
  logic                  play_q, play_d;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  logic                  at_end_now;
  logic                  at_end_next;
  logic                  irq;
  logic                  load;
  logic [23:0]           load_len;
  logic [31:0]           len_ext;
  logic [COUNT_BITS-1:0] len_sat;
  cmd_t                  cmd;

  assign cmd        = head_i.cmd;
  assign pop_o      = head_i.valid && (!out_valid_q || out_ready_i);
  assign at_end_now = (pos_q >= tape_length_i);

  // Execute one command: tick, image byte, motor, play or restart.
  always_comb begin
    rem_d    = rem_q;
    loaded_d = loaded_q;
    late_d   = late_q;
    pos_d    = pos_q;
    phase_d  = phase_q;
    lval_d   = lval_q;
    motor_d  = motor_q;
    play_d   = play_q;
    irq      = 1'b0;
    load     = 1'b0;
    load_len = '0;
    case (cmd.kind)
      CMD_TICK: begin
        if (motor_q) begin
          if (loaded_q) begin
            if (rem_q > COUNT_BITS'(1)) begin
              rem_d = rem_q - 1'b1;
            end else begin
              rem_d    = '0;
              loaded_d = 1'b0;
              irq      = 1'b1;
            end
          end else if (!at_end_now && (pos_q > POS_W'(HEADER_BYTES)) &&
                       (late_q != {COUNT_BITS{1'b1}})) begin
            late_d = late_q + 1'b1;
          end
        end
      end
      CMD_BYTE: begin
        if (!at_end_now) begin
          pos_d = pos_q + 1'b1;
          if (pos_q >= POS_W'(HEADER_BYTES)) begin
            case (phase_q)
              2'd0: begin
                if (!cmd.byte_zero) begin
                  load     = 1'b1;
                  load_len = {13'd0, cmd.value, 3'd0};
                end else begin
                  lval_d  = '0;
                  phase_d = 2'd1;
                end
              end
              2'd1: begin
                lval_d[7:0] = cmd.value;
                phase_d     = 2'd2;
              end
              2'd2: begin
                lval_d[15:8] = cmd.value;
                phase_d      = 2'd3;
              end
              default: begin
                lval_d[23:16] = cmd.value;
                phase_d       = 2'd0;
                load          = 1'b1;
                load_len      = {cmd.value, lval_q[15:0]};
              end
            endcase
          end
        end
      end
      CMD_MOTOR: motor_d = cmd.motor_run;
      CMD_PLAY:  play_d  = !play_q;
      CMD_RESTART: begin
        pos_d    = '0;
        rem_d    = '0;
        loaded_d = 1'b0;
        late_d   = '0;
        phase_d  = 2'd0;
        lval_d   = '0;
      end
      default: ;
    endcase

    // Load a new pulse: saturate to the counter width, then take off late cycles.
    len_ext = {8'd0, load_len};
    len_sat = ((len_ext >> COUNT_BITS) != '0) ? {COUNT_BITS{1'b1}}
                                              : len_ext[COUNT_BITS-1:0];
    if (load) begin
      rem_d    = (len_sat > late_q) ? (len_sat - late_q) : '0;
      loaded_d = 1'b1;
      late_d   = '0;
    end

    // Status after the update.
    at_end_next              = (pos_d >= tape_length_i);
    out_d.pulse_interrupt    = irq;
    out_d.need_byte          = !loaded_d && !at_end_next;
    out_d.end_of_tape        = at_end_next;
    out_d.motor_off_bit      = !motor_d;
    out_d.play_released_bit  = !play_d;
  end

  // Decoder state and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      loaded_q    <= 1'b0;
      late_q      <= '0;
      pos_q       <= '0;
      phase_q     <= 2'd0;
      lval_q      <= '0;
      motor_q     <= 1'b0;
      play_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        rem_q    <= rem_d;
        loaded_q <= loaded_d;
        late_q   <= late_d;
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        lval_q   <= lval_d;
        motor_q  <= motor_d;
        play_q   <= play_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Late cycles only build up while no pulse is loaded.
  `ASSERT_IMPLIES(a_late_when_idle, clk_i, rst_ni, late_q != '0, !loaded_q)
  // A nonzero remaining count always belongs to a loaded pulse.
  `ASSERT_IMPLIES(a_rem_loaded, clk_i, rst_ni, rem_q != '0, loaded_q)
  // An expiry happens only with the motor on, and leaves no pulse loaded.
  `ASSERT_IMPLIES(a_irq_status, clk_i, rst_ni, out_valid_q && out_q.pulse_interrupt, !out_q.motor_off_bit && (out_q.need_byte != out_q.end_of_tape))

endmodule

### tb/tpt_checker.sv
// Checker for the tape pulse timer: watches the item, result and register ports.
// It predicts every status result and compares it with the block's output.
// Depends on tpt_pkg for the item types, operation codes and widths.
module tpt_checker
  import tpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  input  logic             cfg_we_i,
  input  logic [POS_W-1:0] cfg_wdata_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               irq_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int REPORT_LIMIT = 10;

  // Predicted player state and the attached tape length.
  logic [POS_W-1:0]      tape_len;
  logic [POS_W-1:0]      byte_pos;
  logic [POS_W-1:0]      lf_value;
  logic [1:0]            lf_phase;
  logic [COUNT_BITS-1:0] pulse_rem;
  logic [COUNT_BITS-1:0] late_cyc;
  logic                  pulse_on;
  logic                  motor_run;
  logic                  play_down;

  // Status results still owed by the block, oldest first.
  out_item_t expected_status_q[$];
  int        results_seen;

  function automatic bit tape_done();
    return byte_pos >= tape_len;
  endfunction

  // A new pulse absorbs the cycles that were spent waiting for it.
  task automatic load_pulse(input logic [31:0] len);
    logic [COUNT_BITS-1:0] capped;
    capped = (len > 32'(COUNT_MAX)) ? COUNT_MAX : len[COUNT_BITS-1:0];
    pulse_rem = (capped > late_cyc) ? capped - late_cyc : '0;
    pulse_on  = 1'b1;
    late_cyc  = '0;
  endtask

  // Decode one image byte: header skip, short pulse or long-form length.
  task automatic take_byte(input logic [7:0] b);
    logic [POS_W-1:0] pos;
    if (tape_done()) return;
    pos      = byte_pos;
    byte_pos = pos + 1'b1;
    if (pos < HEADER_BYTES) return;
    if (lf_phase == 2'd0) begin
      if (b != 8'd0) begin
        load_pulse({21'd0, b, 3'b000});
      end else begin
        lf_value = '0;
        lf_phase = 2'd1;
      end
    end else begin
      lf_value = lf_value | (POS_W'(b) << (8 * (lf_phase - 1)));
      if (lf_phase == 2'd3) begin
        lf_phase = 2'd0;
        load_pulse(32'(lf_value));
      end else begin
        lf_phase = lf_phase + 1'b1;
      end
    end
  endtask

  // One machine cycle: count the pulse down, or count late cycles.
  function automatic bit run_tick();
    if (!motor_run) return 1'b0;
    if (pulse_on) begin
      if (pulse_rem > 1) begin
        pulse_rem = pulse_rem - 1'b1;
        return 1'b0;
      end
      pulse_rem = '0;
      pulse_on  = 1'b0;
      return 1'b1;
    end
    if (!tape_done() && byte_pos > HEADER_BYTES && late_cyc < COUNT_MAX)
      late_cyc = late_cyc + 1'b1;
    return 1'b0;
  endfunction

  // Apply one item and work out the status the block reports after it.
  task automatic advance_player(input in_item_t item, output out_item_t status);
    bit fired;
    fired = 1'b0;
    case (item.operation)
      OP_TICK:  fired = run_tick();
      OP_BYTE:  take_byte(item.value);
      OP_MOTOR: motor_run = (item.value[0] == 1'b0);
      OP_PLAY:  play_down = !play_down;
      OP_RESTART: begin
        byte_pos  = '0;
        pulse_rem = '0;
        pulse_on  = 1'b0;
        late_cyc  = '0;
        lf_phase  = 2'd0;
        lf_value  = '0;
      end
      default: ;
    endcase
    status.pulse_interrupt   = fired;
    status.need_byte         = !pulse_on && !tape_done();
    status.end_of_tape       = tape_done();
    status.motor_off_bit     = !motor_run;
    status.play_released_bit = !play_down;
  endtask

  // Watch all three ports at each edge: register writes, item and result transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      tape_len  = '0;
      byte_pos  = '0;
      lf_value  = '0;
      lf_phase  = 2'd0;
      pulse_rem = '0;
      late_cyc  = '0;
      pulse_on  = 1'b0;
      motor_run = 1'b0;
      play_down = 1'b0;
      expected_status_q.delete();
      results_seen = 0;
      fail_count_o = 0;
      pending_o    = 0;
      irq_count_o  = 0;
    end else begin
      if (cfg_we_i) tape_len = cfg_wdata_i;

      if (in_valid_i && in_ready_i) begin
        advance_player(in_data_i, want);
        expected_status_q.push_back(want);
        if (want.pulse_interrupt) irq_count_o++;
      end

      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_status_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: result %0d arrived with nothing expected: got %b",
                     $time, results_seen, out_data_i);
        end else begin
          want = expected_status_q.pop_front();
          if (out_data_i.pulse_interrupt !== want.pulse_interrupt ||
              out_data_i.need_byte !== want.need_byte ||
              out_data_i.end_of_tape !== want.end_of_tape ||
              out_data_i.motor_off_bit !== want.motor_off_bit ||
              out_data_i.play_released_bit !== want.play_released_bit) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT)
              $display({"%0t: result %0d mismatch (irq need end motor_off play_rel):",
                        " expected %b %b %b %b %b, got %b %b %b %b %b"},
                       $time, results_seen,
                       want.pulse_interrupt, want.need_byte, want.end_of_tape,
                       want.motor_off_bit, want.play_released_bit,
                       out_data_i.pulse_interrupt, out_data_i.need_byte,
                       out_data_i.end_of_tape, out_data_i.motor_off_bit,
                       out_data_i.play_released_bit);
          end
        end
      end
      pending_o = expected_status_q.size();
    end
  end

endmodule

### tb/tb.sv
// Top of the tape pulse timer testbench: clock, reset, stimulus and verdict.
// Drives the block and the register port; tpt_checker does the prediction.
// Depends on tpt_pkg, tape_pulse_timer and tpt_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned LONG_HOLD    = 300;
  localparam logic [POS_W-1:0] LEN_MAX = '1;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int irq_count;

  // Stimulus bookkeeping: transfers that do something, bytes fed since restart.
  int unsigned      items_sent = 0;
  int unsigned      sessions = 0;
  int unsigned      bytes_fed = 0;
  logic [POS_W-1:0] tape_len_now = '0;

  // Flow control knobs shared between the sender and the result sink.
  bit hold_req      = 1'b0;
  bit sender_steady = 1'b0;
  bit sink_steady   = 1'b0;

  tape_pulse_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  tpt_checker status_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .irq_count_o  (irq_count)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  // Idle length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result sink: random stalls, steady stretches and one long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (sink_steady || $urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        stall = idle_len() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  // Offer one item, hold it until the transfer, then maybe go idle.
  task automatic send_item(input logic [2:0] op, input logic [7:0] val);
    in_item_t    item;
    int unsigned gap;
    item.operation = op;
    item.value     = val;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    // Bytes past the end and unused codes change nothing, so they are not counted.
    if (op == OP_BYTE) begin
      if (bytes_fed < tape_len_now) begin
        bytes_fed++;
        items_sent++;
      end
    end else if (op == OP_RESTART) begin
      bytes_fed = 0;
      items_sent++;
    end else if (op < OP_RESTART) begin
      items_sent++;
    end
    gap = (sender_steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until every result has come back, then let the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_tape_length(input logic [POS_W-1:0] len);
    wait_idle();
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tape_len_now = len;
  endtask

  // One tape: restart, header, then pulse records each followed by ticks and noise.
  task automatic play_session(input int unsigned n_recs);
    int unsigned i;
    int unsigned k;
    int unsigned kind;
    int unsigned ticks;
    int unsigned r;
    logic [23:0] len;
    logic [7:0]  b;
    sessions++;
    send_item(OP_RESTART, 8'($urandom));
    if ($urandom_range(0, 3) != 0) send_item(OP_MOTOR, 8'($urandom) & 8'hFE);
    for (i = 0; i < HEADER_BYTES; i++) send_item(OP_BYTE, 8'($urandom));
    for (i = 0; i < n_recs; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        b = 8'($urandom_range(1, 4));
        send_item(OP_BYTE, b);
        len = {13'd0, b, 3'b000};
      end else if (kind < 6) begin
        b = 8'($urandom_range(1, 255));
        send_item(OP_BYTE, b);
        len = {13'd0, b, 3'b000};
      end else begin
        // Long form: mostly short lengths, zero among them, now and then any length.
        len = (kind < 9) ? 24'($urandom_range(0, 40)) : 24'($urandom);
        send_item(OP_BYTE, 8'h00);
        for (k = 0; k < 3; k++) begin
          if ($urandom_range(0, 4) == 0) send_item(OP_TICK, 8'($urandom));
          send_item(OP_BYTE, len[8*k +: 8]);
        end
      end
      // Enough ticks to expire the pulse and run late, or too few so the next
      // byte replaces a pulse still loaded.
      ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) :
              len + $urandom_range(0, 6);
      if (ticks > 60) ticks = $urandom_range(20, 60);
      for (k = 0; k < ticks; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_item(OP_MOTOR, 8'($urandom));
        else if (r < 5) send_item(OP_PLAY, 8'($urandom));
        else if (r < 6) send_item(3'($urandom_range(5, 7)), 8'($urandom));
        else send_item(OP_TICK, 8'($urandom));
      end
    end
  endtask

  // Reset, directed items, random tapes, then the verdict.
  initial begin
    int unsigned r;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no tape attached, unused codes, stopped and running motor, play toggles, restarts.
    set_tape_length('0);
    send_item(3'd5, 8'hFF);
    send_item(3'd6, 8'h00);
    send_item(3'd7, 8'hAA);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_PLAY, 8'h00);
    send_item(OP_PLAY, 8'hFF);
    send_item(OP_MOTOR, 8'hFE);
    send_item(OP_TICK, 8'h00);
    send_item(OP_MOTOR, 8'h01);
    send_item(OP_TICK, 8'h55);
    send_item(OP_MOTOR, 8'hFF);
    send_item(OP_MOTOR, 8'h00);
    send_item(OP_RESTART, 8'hFF);
    send_item(OP_RESTART, 8'h00);

    // Longest tape, the sender running flat out into a long result hold-off.
    set_tape_length(LEN_MAX);
    sender_steady = 1'b1;
    sink_steady   = 1'b0;
    hold_req      = 1'b1;
    play_session(6);

    // Random tapes under varying lengths and flow control.
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) set_tape_length(LEN_MAX);
      else if (r < 70) set_tape_length(POS_W'(HEADER_BYTES + $urandom_range(0, 12)));
      else if (r < 80) set_tape_length(POS_W'($urandom_range(0, HEADER_BYTES - 1)));
      else if (r < 90) set_tape_length(POS_W'($urandom));
      else if (r < 95) set_tape_length('0);
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      play_session($urandom_range(3, 10));
    end

    wait_idle();
    $display("Run covered %0d effective transfers over %0d tape sessions.",
             items_sent, sessions);
    $display("Pulse interrupts predicted and checked: %0d.", irq_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
